### hdl/sorted_insert_stack_macros.svh
// Assertion macros shared by the sorted insert stack RTL.
`ifndef SORTED_INSERT_STACK_MACROS_SVH
`define SORTED_INSERT_STACK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SIS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_insert_stack: assertion failed");

// Next-cycle implication, disabled during reset.
`define SIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_insert_stack: assertion failed");

`endif

### hdl/sis_pkg.sv
// Package with sizes, opcodes and cell control type of the sorted insert stack.
package sis_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic                       ins;
    logic                       rem;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctrl_t;

endpackage

### hdl/sorted_insert_stack.sv
// Top level of the sorted insert stack: a shift-register min priority queue.
//
// Input channel s_axis: tuser carries the opcode (insert or remove), tdata the
// signed 32-bit value to insert. Output channel m_axis: one result item per
// input item with the top value, the count, an empty flag and an error flag.
// The store is a chain of DEPTH cells; cell 0 holds the smallest value. On an
// insert every cell compares its value with the new one and either keeps its
// value, takes the new one, or takes the value of the cell above; on a remove
// every cell takes the value of the cell below. All cells move in the same cycle.
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver takes each result.
// An insert into a full store or a remove from an empty one leaves the store
// unchanged and reports error. Reset empties the store (count zero) and drops
// any pending result; cell contents are not cleared. When the receiver stalls
// the result is held in the output register and s_axis_tready_o drops until
// the result is taken.
`include "sorted_insert_stack_macros.svh"
module sorted_insert_stack
  import sis_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] value
  input  logic        s_axis_tuser_i,  // [0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // [31:0] top_value, [36:32] count,
                                       // [37] empty_res, [38] error, [39] zero
);

  logic [CNT_W-1:0]          count_q, count_d;
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_top_q;
  logic [COUNT_W-1:0]        out_count_q;
  logic                      out_empty_q, out_error_q;

  logic                      in_acc, is_full, is_empty, ins_ok, rem_ok, err;
  cell_ctrl_t                ctrl;

  logic                      smaller [DEPTH];
  logic signed [VALUE_W-1:0] cell_q  [DEPTH];
  logic signed [VALUE_W-1:0] cell_d  [DEPTH];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_full         = (count_q == CNT_W'(DEPTH));
  assign is_empty        = (count_q == '0);
  assign ins_ok          = in_acc && (s_axis_tuser_i == OP_INSERT) && !is_full;
  assign rem_ok          = in_acc && (s_axis_tuser_i == OP_REMOVE) && !is_empty;
  assign err             = ((s_axis_tuser_i == OP_INSERT) && is_full) ||
                           ((s_axis_tuser_i == OP_REMOVE) && is_empty);

  assign ctrl.ins   = ins_ok;
  assign ctrl.rem   = rem_ok;
  assign ctrl.value = $signed(s_axis_tdata_i);

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (rem_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      occ, above_sm;
    logic signed [VALUE_W-1:0] above_v, below_v;

    assign occ = (count_q > CNT_W'(i));

    if (i == 0) begin : g_first
      assign above_sm = 1'b1;
      assign above_v  = '0;
    end else begin : g_mid
      assign above_sm = smaller[i-1];
      assign above_v  = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign below_v = '0;
    end else begin : g_inner
      assign below_v = cell_q[i+1];
    end

    sis_cell u_cell (
      .clk_i           (clk_i),
      .ctrl_i          (ctrl),
      .occupied_i      (occ),
      .above_smaller_i (above_sm),
      .above_value_i   (above_v),
      .below_value_i   (below_v),
      .smaller_o       (smaller[i]),
      .value_o         (cell_q[i]),
      .value_d_o       (cell_d[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_top_q   <= (count_d != '0) ? cell_d[0] : '0;
      out_count_q <= COUNT_W'(count_d);
      out_empty_q <= (count_d == '0);
      out_error_q <= err;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_error_q, out_empty_q, out_count_q, out_top_q};

  `SIS_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(DEPTH))
  `SIS_ASSERT_NEXT(a_insert_count, clk_i, rst_ni, ins_ok, count_q == $past(count_q) + CNT_W'(1))
  `SIS_ASSERT_IMPL(a_error_edge, clk_i, rst_ni, out_valid_q && out_error_q, is_empty || is_full)
  `SIS_ASSERT_IMPL(a_top_order, clk_i, rst_ni, count_q > CNT_W'(1), cell_q[0] <= cell_q[1])

endmodule

### hdl/sis_cell.sv
// One slot of the sorted chain: holds a value and shifts with its neighbors.
module sis_cell
  import sis_pkg::*;
(
  input  logic                      clk_i,
  input  cell_ctrl_t                ctrl_i,
  input  logic                      occupied_i,
  input  logic                      above_smaller_i,
  input  logic signed [VALUE_W-1:0] above_value_i,
  input  logic signed [VALUE_W-1:0] below_value_i,
  output logic                      smaller_o,
  output logic signed [VALUE_W-1:0] value_o,
  output logic signed [VALUE_W-1:0] value_d_o
);

  logic signed [VALUE_W-1:0] value_q, value_d;

  always_comb begin
    smaller_o = occupied_i && (value_q < ctrl_i.value);
    value_d   = value_q;
    if (ctrl_i.ins) begin
      priority if (smaller_o) begin
        value_d = value_q;
      end else if (above_smaller_i) begin
        value_d = ctrl_i.value;
      end else begin
        value_d = above_value_i;
      end
    end else if (ctrl_i.rem) begin
      value_d = below_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o   = value_q;
  assign value_d_o = value_d;

endmodule

### sim/sorted_insert_stack_test.sv
// Self-checking stream testbench for the sorted insert stack min priority queue.
`timescale 1ns / 1ps
module sorted_insert_stack_test;
  import sis_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS   = 1400;

  typedef struct packed {
    logic                      pad;
    logic                      err;
    logic                      empty;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] top_val;
  } queue_status_t;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_RUNS,
    READY_RARE_DROP
  } ready_mode_e;

  class status_board;
    logic signed [VALUE_W-1:0] slots[$];
    queue_status_t             awaited[$];
    int unsigned               errors;

    task flag_mismatch(string what, logic [VALUE_W-1:0] got,
                       logic [VALUE_W-1:0] want);
      $display("%0t MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    function void note_op(logic op, logic signed [VALUE_W-1:0] value);
      queue_status_t s;
      int unsigned   pos;
      s = '0;
      if (op == OP_INSERT) begin
        if (slots.size() >= DEPTH) begin
          s.err = 1'b1;
        end else begin
          pos = 0;
          while (pos < slots.size() && slots[pos] < value) pos++;
          slots.insert(pos, value);
        end
      end else begin
        if (slots.size() == 0) begin
          s.err = 1'b1;
        end else begin
          void'(slots.pop_front());
        end
      end
      s.top_val = (slots.size() != 0) ? slots[0] : '0;
      s.count   = COUNT_W'(slots.size());
      s.empty   = (slots.size() == 0);
      awaited.insert(awaited.size(), s);
    endfunction

    task check_status(logic [39:0] word);
      queue_status_t got;
      queue_status_t want;
      got = word;
      if (awaited.size() == 0) begin
        flag_mismatch("result with nothing awaited", word[31:0], '0);
        return;
      end
      want = awaited.pop_front();
      if (got.top_val !== want.top_val) flag_mismatch("top_value", got.top_val, want.top_val);
      if (got.count !== want.count) flag_mismatch("count", got.count, want.count);
      if (got.empty !== want.empty) flag_mismatch("empty", got.empty, want.empty);
      if (got.err !== want.err) flag_mismatch("error", got.err, want.err);
      if (got.pad !== 1'b0) flag_mismatch("padding", got.pad, 1'b0);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [31:0] value
  logic        s_axis_tuser_i;   // [0] opcode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;   // [31:0] top_value, [36:32] count,
                                 // [37] empty_res, [38] error, [39] zero

  status_board board;

  sorted_insert_stack dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) board.note_op(s_axis_tuser_i, s_axis_tdata_i);
    if (m_axis_tvalid_o && m_axis_tready_i) board.check_status(m_axis_tdata_o);
  end

  ready_mode_e ready_mode;
  int          mode_left = 0;
  int          run_left  = 0;
  bit          run_level = 1'b0;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(50, 200);
    end
    mode_left--;
    case (ready_mode)
      READY_ALWAYS: m_axis_tready_i <= 1'b1;
      READY_COIN: m_axis_tready_i <= 1'($urandom_range(0, 1));
      READY_RUNS: begin
        if (run_left == 0) begin
          run_level = !run_level;
          run_left  = $urandom_range(1, 25);
        end
        run_left--;
        m_axis_tready_i <= run_level;
      end
      default: m_axis_tready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_item(input logic op, input logic [31:0] value);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= value;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.awaited.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] corner[6];
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
               32'h8000_0001, 32'h7fff_fffe};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7: return 32'($signed($urandom_range(0, 15)) - 8);
      default: return corner[$urandom_range(0, 5)];
    endcase
  endfunction

  initial begin
    logic [31:0] seed_vals[16];
    int unsigned sent;
    int unsigned phase_len;
    int unsigned ins_pct;
    int unsigned burst_left;
    bit          gaps_on;
    bit          first_phase;
    seed_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                  32'h8000_0000, 32'h0000_0005, 32'h0000_0005, 32'h7fff_ffff,
                  32'hffff_fffb, 32'h0000_0001, 32'h8000_0001, 32'h7fff_fffe,
                  32'h0000_0003, 32'hffff_fffd, 32'h0000_0000, 32'h0000_0002};
    board = new;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tuser_i  <= OP_INSERT;
    s_axis_tdata_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // remove on empty, fill with extremes and ties, insert on full, partial drain
    send_item(OP_REMOVE, 32'hffff_ffff);
    foreach (seed_vals[i]) send_item(OP_INSERT, seed_vals[i]);
    send_item(OP_INSERT, 32'h5555_5555);
    send_item(OP_REMOVE, 32'haaaa_aaaa);
    send_item(OP_REMOVE, 32'h0000_0000);
    send_item(OP_REMOVE, 32'hffff_ffff);
    send_item(OP_REMOVE, 32'h5555_5555);

    sent        = 0;
    burst_left  = 0;
    first_phase = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 120);
      case ($urandom_range(0, 2))
        0: ins_pct = 85;
        1: ins_pct = 15;
        default: ins_pct = 50;
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (phase_len) begin
        if (gaps_on && burst_left == 0) begin
          s_axis_tvalid_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
          burst_left = $urandom_range(1, 24);
        end
        send_item(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE, pick_value());
        if (burst_left > 0) burst_left--;
        sent++;
      end
      // after the first phase and some later ones, hold off until every result is back
      if (first_phase || $urandom_range(0, 2) == 0) wait_drained();
      first_phase = 1'b0;
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sorted_insert_stack.f
+incdir+hdl
hdl/sis_pkg.sv
hdl/sis_cell.sv
hdl/sorted_insert_stack.sv
sim/sorted_insert_stack_test.sv
